[hw/rtl/ftpt_pkg.sv]
// Shared types and codes for the frame time position table.
`timescale 1ns / 1ps
`default_nettype none

package ftpt_pkg;

  localparam int FRAME_W = 32;
  localparam int TIME_W  = 16;
  // Holds (capacity_seconds + 1) * frame rate for rates up to 120.
  localparam int LIMIT_W = 24;

  localparam logic [TIME_W-1:0] EMPTY_TIME = {(TIME_W/8){8'hFF}};

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_MOUNTED = 2'd1;
  localparam logic [1:0] ST_RANGE       = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd3;

  localparam logic [1:0] CFG_MOUNTED     = 2'd0;
  localparam logic [1:0] CFG_FIRST_FRAME = 2'd1;
  localparam logic [1:0] CFG_CAPACITY    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FRAME_W-1:0] frame_number;
    logic [TIME_W-1:0]  time_value;
  } ftpt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic [TIME_W-1:0]  time_out;
  } ftpt_out_t;

  typedef struct packed {
    logic               mounted;
    logic [FRAME_W-1:0] first_frame;
    logic [LIMIT_W-1:0] frame_limit;
  } ftpt_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SEARCH,
    S_EMIT
  } ftpt_state_t;

endpackage

`default_nettype wire

[hw/rtl/ftpt_cfg.sv]
// Configuration registers and the precomputed writable frame limit.
`timescale 1ns / 1ps
`default_nettype none

module ftpt_cfg
  import ftpt_pkg::*;
#(
  parameter int FRAMES_PER_SECOND = 25
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [FRAME_W-1:0] cfg_wdata,
  output ftpt_cfg_t               cfg
);

  logic               mounted_r, mounted_nxt;
  logic [FRAME_W-1:0] first_frame_r, first_frame_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [TIME_W:0]    cap_p1;

  assign cap_p1 = {1'b0, cfg_wdata[TIME_W-1:0]} + {{TIME_W{1'b0}}, 1'b1};

  always_comb begin
    mounted_nxt     = mounted_r;
    first_frame_nxt = first_frame_r;
    limit_nxt       = limit_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MOUNTED:     mounted_nxt = cfg_wdata[0];
        CFG_FIRST_FRAME: first_frame_nxt = cfg_wdata;
        CFG_CAPACITY:    limit_nxt = LIMIT_W'(cap_p1 * FRAMES_PER_SECOND);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mounted_r     <= 1'b0;
      first_frame_r <= FRAME_W'(1);
      limit_r       <= LIMIT_W'(FRAMES_PER_SECOND);
    end else begin
      mounted_r     <= mounted_nxt;
      first_frame_r <= first_frame_nxt;
      limit_r       <= limit_nxt;
    end
  end

  assign cfg.mounted     = mounted_r;
  assign cfg.first_frame = first_frame_r;
  assign cfg.frame_limit = limit_r;

endmodule

`default_nettype wire

[hw/rtl/ftpt_mem.sv]
// Time stamp memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ftpt_mem
  import ftpt_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/ftpt_seq.sv]
// Request sequencer: range checks, memory access, table walk and result register.
`timescale 1ns / 1ps
`default_nettype none

module ftpt_seq
  import ftpt_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ftpt_cfg_t         cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ftpt_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ftpt_out_t              out_data,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [TIME_W-1:0] mem_wdata,
  output logic                   mem_re,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [TIME_W-1:0] mem_rdata
);

  localparam int EXT_W = FRAME_W + 1 - AW;

  ftpt_state_t        state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [FRAME_W-1:0] off_r, off_nxt;
  logic               under_r, under_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic               e0_r, e0_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  ftpt_out_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ftpt_out_t          out_data_r, out_data_nxt;

  logic               done;
  logic               out_free;
  ftpt_out_t          res;
  logic [FRAME_W:0]   off_x;
  logic [FRAME_W:0]   end_x;
  logic [FRAME_W:0]   end_p1;
  logic               upd_bad;
  logic               look_bad;
  logic [TIME_W-1:0]  entry;

  assign out_free = !out_valid_r || out_ready;
  assign off_x    = {1'b0, off_r};
  assign end_x    = {{EXT_W{1'b0}}, end_r};
  assign end_p1   = end_x + {{FRAME_W{1'b0}}, 1'b1};
  assign upd_bad  = under_r || (off_x > end_p1)
                 || (off_r >= {{(FRAME_W-LIMIT_W){1'b0}}, cfg.frame_limit})
                 || (off_x >= (FRAME_W+1)'(DEPTH));
  assign look_bad = under_r || (off_x > end_x);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = out_free ? S_IDLE : S_EMIT;
        end else if (mode_r == MODE_SEARCH) begin
          state_nxt = S_SEARCH;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = out_free ? S_IDLE : S_EMIT;
      end
      S_SEARCH: begin
        if (done) begin
          state_nxt = out_free ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    frame_nxt     = frame_r;
    time_nxt      = time_r;
    off_nxt       = off_r;
    under_nxt     = under_r;
    end_nxt       = end_r;
    e0_nxt        = e0_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    done          = 1'b0;
    res           = '0;
    mem_we        = 1'b0;
    mem_waddr     = off_r[AW-1:0];
    mem_wdata     = time_r;
    mem_re        = 1'b0;
    mem_raddr     = off_r[AW-1:0];
    entry         = mem_rdata;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt             = in_data.mode;
          frame_nxt            = in_data.frame_number;
          time_nxt             = in_data.time_value;
          {under_nxt, off_nxt} = {1'b0, in_data.frame_number} - {1'b0, cfg.first_frame};
        end
      end
      S_EXEC: begin
        if (!cfg.mounted) begin
          done       = 1'b1;
          res.status = ST_NOT_MOUNTED;
        end else begin
          case (mode_r)
            MODE_UPDATE: begin
              done = 1'b1;
              if (upd_bad) begin
                res.status = ST_RANGE;
              end else begin
                mem_we        = 1'b1;
                res.status    = ST_OK;
                res.frame_out = frame_r;
                res.time_out  = time_r;
                if (off_x == end_p1) begin
                  end_nxt = off_r[AW-1:0];
                end
                if (off_r == '0) begin
                  e0_nxt = 1'b1;
                end
              end
            end
            MODE_LOOKUP: begin
              if (look_bad) begin
                done       = 1'b1;
                res.status = ST_RANGE;
              end else begin
                mem_re = 1'b1;
              end
            end
            MODE_SEARCH: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_nxt   = '0;
            end
            default: begin
              done       = 1'b1;
              res.status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_READ: begin
        done          = 1'b1;
        res.status    = ST_OK;
        res.frame_out = frame_r;
        res.time_out  = (off_r == '0 && !e0_r) ? EMPTY_TIME : mem_rdata;
      end
      S_SEARCH: begin
        entry = (idx_r == '0 && !e0_r) ? EMPTY_TIME : mem_rdata;
        if (entry == EMPTY_TIME) begin
          done       = 1'b1;
          res.status = ST_NOT_FOUND;
        end else if (entry == time_r) begin
          done          = 1'b1;
          res.status    = ST_OK;
          res.frame_out = cfg.first_frame + {{(FRAME_W-AW){1'b0}}, idx_r};
          res.time_out  = time_r;
        end else if (idx_r == end_r) begin
          done       = 1'b1;
          res.status = ST_NOT_FOUND;
        end else begin
          idx_nxt   = idx_r + {{(AW-1){1'b0}}, 1'b1};
          mem_re    = 1'b1;
          mem_raddr = idx_nxt;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_r       <= '0;
      e0_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      end_r       <= end_nxt;
      e0_r        <= e0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    frame_r    <= frame_nxt;
    time_r     <= time_nxt;
    off_r      <= off_nxt;
    under_r    <= under_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/frame_time_position_table.sv]
// Top level of the frame time position table.
//
// The table maps frame numbers, counted from first_frame, to 16-bit time stamps
// held in one synchronous memory of DEPTH words. One request is handled at a
// time; a finished result waits in an output register while the next word is
// accepted. An update finishes in the execute state, a lookup also passes the
// read state for the registered memory read, and a search reads one entry at
// a time, paced by the single memory read port. Apart from entry 0, which
// carries one flag of its own, unwritten entries all lie past the filled end
// and are never read, so the memory needs no clearing pass after reset and is
// ready at once. The user must write configuration only while no request is
// in progress; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module frame_time_position_table
  import ftpt_pkg::*;
#(
  parameter int DEPTH             = 65536,
  parameter int FRAMES_PER_SECOND = 25
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [FRAME_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ftpt_in_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ftpt_out_t               out_data
);

  localparam int AW = $clog2(DEPTH);

  ftpt_cfg_t         cfg;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [TIME_W-1:0] mem_rdata;

  ftpt_cfg #(
    .FRAMES_PER_SECOND(FRAMES_PER_SECOND)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  ftpt_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ftpt_seq #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

endmodule

`default_nettype wire

[dv/frame_time_position_table_test.sv]
// Self-checking testbench for the frame time position table.
`timescale 1ns / 1ps

module frame_time_position_table_test;
  import ftpt_pkg::*;

  localparam int DEPTH      = 65536;
  localparam int FRAME_RATE = 25;
  localparam int WATCHDOG   = 200000;
  localparam int MAX_REPORTS = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_MOUNTED;
  logic [FRAME_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ftpt_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ftpt_out_t         out_data;

  ftpt_in_t    pending_requests [$];
  ftpt_out_t   expected_answers [$];

  logic [TIME_W-1:0]  time_mem [0:DEPTH-1];
  int unsigned        end_off = 0;
  logic               mnt = 1'b0;
  logic [FRAME_W-1:0] base_frame = 32'd1;
  logic [TIME_W-1:0]  cap_sec = '0;

  logic steady = 1'b0;
  int   fail_count = 0;
  int   reports = 0;
  int   idle_cycles = 0;
  int   status_count [4] = '{0, 0, 0, 0};

  frame_time_position_table #(
    .DEPTH(DEPTH),
    .FRAMES_PER_SECOND(FRAME_RATE)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ftpt_out_t table_answer(input ftpt_in_t w);
    ftpt_out_t          r;
    logic [FRAME_W-1:0] off;
    int unsigned        i;
    logic               hit;
    r = '0;
    off = w.frame_number - base_frame;
    hit = 1'b0;
    if (!mnt) begin
      r.status = ST_NOT_MOUNTED;
    end else begin
      case (w.mode)
        MODE_UPDATE: begin
          if (w.frame_number < base_frame || off > end_off + 1 ||
              off / FRAME_RATE > cap_sec || off >= DEPTH) begin
            r.status = ST_RANGE;
          end else begin
            if (off == end_off + 1) end_off = off;
            time_mem[off] = w.time_value;
            r.status = ST_OK;
            r.frame_out = w.frame_number;
            r.time_out = w.time_value;
          end
        end
        MODE_LOOKUP: begin
          if (w.frame_number < base_frame || off > end_off) begin
            r.status = ST_RANGE;
          end else begin
            r.status = ST_OK;
            r.frame_out = w.frame_number;
            r.time_out = time_mem[off];
          end
        end
        MODE_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (i = 0; i <= end_off && !hit && time_mem[i] != EMPTY_TIME; i++) begin
            if (time_mem[i] == w.time_value) begin
              hit = 1'b1;
              r.status = ST_OK;
              r.frame_out = base_frame + i;
              r.time_out = w.time_value;
            end
          end
        end
        default: r.status = ST_NOT_FOUND;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(table_answer(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 6)) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    ftpt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          end
        end else begin
          want = expected_answers.pop_front();
          status_count[want.status]++;
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("frame_out", want.frame_out, out_data.frame_out);
          check_field("time_out", 32'(want.time_out), 32'(out_data.time_out));
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [31:0] frame,
                           input logic [15:0] tval);
    ftpt_in_t w;
    w.mode = mode;
    w.frame_number = frame;
    w.time_value = tval;
    while (pending_requests.size() >= 2) @(negedge clk);
    pending_requests.push_back(w);
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (index)
      CFG_MOUNTED:     mnt = value[0];
      CFG_FIRST_FRAME: base_frame = value;
      CFG_CAPACITY:    cap_sec = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_random(input int count);
    logic [1:0]  mode;
    logic [31:0] frame;
    logic [15:0] tval;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      mode = pick < 45 ? MODE_UPDATE : pick < 68 ? MODE_LOOKUP :
             pick < 96 ? MODE_SEARCH : MODE_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 30) frame = base_frame + end_off + 1;
      else if (pick < 35) frame = base_frame + end_off + 2;
      else if (pick < 80) frame = base_frame + $urandom_range(0, end_off);
      else if (pick < 90) frame = $urandom;
      else frame = base_frame - $urandom_range(1, 3);
      pick = $urandom_range(0, 99);
      if (mode == MODE_SEARCH && pick < 55) tval = time_mem[$urandom_range(0, end_off)];
      else if (pick >= 94) tval = EMPTY_TIME;
      else if (pick >= 88) tval = '0;
      else tval = 16'($urandom);
      send_word(mode, frame, tval);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) time_mem[i] = EMPTY_TIME;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_word(MODE_UPDATE, 32'd1, 16'h1111);
    send_word(MODE_LOOKUP, 32'd1, 16'h0000);
    send_word(MODE_SEARCH, 32'd0, 16'hFFFF);
    send_word(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    drain();
    write_reg(CFG_MOUNTED, 32'd1);
    write_reg(CFG_FIRST_FRAME, 32'd100);
    write_reg(CFG_CAPACITY, 32'd2);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

    send_word(MODE_LOOKUP, 32'd100, 16'h0000);
    send_word(MODE_SEARCH, 32'd0, 16'h1234);
    send_word(MODE_LOOKUP, 32'd99, 16'h0000);
    send_word(MODE_LOOKUP, 32'd101, 16'h0000);
    send_word(MODE_UPDATE, 32'd99, 16'h0001);
    send_word(MODE_UPDATE, 32'd102, 16'h0002);
    send_word(MODE_UPDATE, 32'd100, 16'h0000);
    send_word(MODE_UPDATE, 32'd101, 16'hFFFF);
    send_word(MODE_UPDATE, 32'd102, 16'h00AA);
    send_word(MODE_SEARCH, 32'hFFFF_FFFF, 16'h00AA);
    send_word(MODE_UPDATE, 32'd101, 16'h5555);
    send_word(MODE_SEARCH, 32'd0, 16'h00AA);
    send_word(MODE_SEARCH, 32'd0, 16'h0000);
    send_word(MODE_SEARCH, 32'd0, 16'hFFFF);
    send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_UPDATE, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_UPDATE, 32'd0, 16'h0003);

    drain();
    write_reg(CFG_CAPACITY, 32'hABCD_0001);
    send_random(300);
    drain();
    write_reg(CFG_CAPACITY, 32'd0);
    send_random(150);
    drain();
    write_reg(CFG_FIRST_FRAME, 32'hFFFF_FFFF);
    send_random(100);
    drain();
    write_reg(CFG_FIRST_FRAME, 32'd0);
    write_reg(CFG_CAPACITY, 32'h0000_FFFF);
    steady = 1'b1;
    send_random(300);
    drain();
    steady = 1'b0;
    write_reg(CFG_MOUNTED, 32'hFFFF_FFFE);
    send_random(50);
    drain();
    write_reg(CFG_MOUNTED, 32'd3);
    write_reg(CFG_FIRST_FRAME, 32'h1234_5678);
    send_random(150);
    drain();

    write_reg(CFG_FIRST_FRAME, 32'd0);
    send_word(MODE_UPDATE, DEPTH, 16'h0001);
    send_word(MODE_LOOKUP, DEPTH - 1, 16'h0000);
    send_word(MODE_LOOKUP, DEPTH, 16'h0000);
    send_word(MODE_SEARCH, 32'd0, 16'hFFFE);
    send_word(MODE_SEARCH, 32'd0, 16'hFFFF);
    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d not mounted, %0d out of range, %0d not found.",
             status_count[0] + status_count[1] + status_count[2] + status_count[3],
             status_count[0], status_count[1], status_count[2], status_count[3]);
    $display("Table end reached offset %0d; first frame and capacity went through their extremes.",
             end_off);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
